@@ hdl/direct_form_one_iir_fir_filter_assert.svh @@
// ----------------------------------------------------------------------------
// direct_form_one_iir_fir_filter_assert.svh
// Assertion macros used by the filter top level.
// ----------------------------------------------------------------------------
`ifndef DIRECT_FORM_ONE_IIR_FIR_FILTER_ASSERT_SVH
`define DIRECT_FORM_ONE_IIR_FIR_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DFIIR_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("filter assertion failed (same cycle)");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DFIIR_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("filter assertion failed (next cycle)");

`endif

@@ hdl/dfiir_pkg.sv @@
// ----------------------------------------------------------------------------
// dfiir_pkg
// Types and constants of the direct form I filter.
// ----------------------------------------------------------------------------
package dfiir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_SHIFT = 14;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int NUM_COEF   = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 38'sd8192;
    localparam logic signed [RND_W-1:0] RND_MAX    = 24'sd32767;
    localparam logic signed [RND_W-1:0] RND_MIN    = -24'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0     = 3'd0,
        REG_COEF_B1     = 3'd1,
        REG_COEF_B2     = 3'd2,
        REG_COEF_B3     = 3'd3,
        REG_COEF_A1     = 3'd4,
        REG_COEF_A2     = 3'd5,
        REG_COEF_A3     = 3'd6,
        REG_FEEDBACK_EN = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_PRESET = 1'b1
    } op_t;

    typedef struct packed {
        logic shift;
        logic preset;
        logic feedback;
    } cell_ctrl_t;

    typedef struct packed {
        logic                       saturated;
        logic signed [SAMPLE_W-1:0] filtered;
    } result_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

@@ hdl/dfiir_cell.sv @@
// ----------------------------------------------------------------------------
// dfiir_cell
// One tap of the filter: holds one input and one output history entry, shifts
// them on from its neighbor, adds its b product, subtracts its gated a product.
// ----------------------------------------------------------------------------
module dfiir_cell
    import dfiir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] preset_value,
    input  logic signed [SAMPLE_W-1:0] u_in,
    input  logic signed [SAMPLE_W-1:0] y_in,
    input  logic signed [COEF_W-1:0]   coef_b,
    input  logic signed [COEF_W-1:0]   coef_a,
    input  logic signed [ACC_W-1:0]    acc_in,
    output logic signed [SAMPLE_W-1:0] u_out,
    output logic signed [SAMPLE_W-1:0] y_out,
    output logic signed [ACC_W-1:0]    acc_out
);

    logic signed [SAMPLE_W-1:0] u_reg, u_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [PROD_W-1:0]   prod_b;
    logic signed [PROD_W-1:0]   prod_a;
    logic signed [ACC_W-1:0]    fb_term;

    // The registers hold the entries that sit one place closer to the
    // input, so after the shift they are exactly this tap's operands.
    assign prod_b  = coef_b * u_reg;
    assign prod_a  = coef_a * y_reg;
    assign fb_term = ctrl.feedback ? ACC_W'(prod_a) : {ACC_W{1'b0}};
    assign acc_out = acc_in + ACC_W'(prod_b) - fb_term;

    always_comb
    begin
        u_next = u_reg;
        y_next = y_reg;
        priority if (ctrl.preset)
        begin
            u_next = preset_value;
            y_next = preset_value;
        end
        else if (ctrl.shift)
        begin
            u_next = u_in;
            y_next = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            u_reg <= u_next;
            y_reg <= y_next;
        end
    end

    assign u_out = u_reg;
    assign y_out = y_reg;

endmodule

@@ hdl/dfiir_outbuf.sv @@
// ----------------------------------------------------------------------------
// dfiir_outbuf
// Output register with a skid stage, so the filter keeps taking samples
// while a result waits for the downstream side.
// ----------------------------------------------------------------------------
module dfiir_outbuf
    import dfiir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     push_data,
    input  logic        pop_ready,
    output result_t     out_data,
    output buf_status_t status
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && pop_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (!out_valid_reg || pop)
        begin
            // The output slot frees up: the oldest waiting result moves in.
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_data          = out_data_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

@@ hdl/direct_form_one_iir_fir_filter.sv @@
// ----------------------------------------------------------------------------
// direct_form_one_iir_fir_filter
// Direct form I IIR/FIR filter built from a row of tap cells.
// ----------------------------------------------------------------------------
// The filter takes one transaction per clock while the skid entry is empty, and
// returns each filtered sample through the registered output buffer; a preset
// transaction loads both histories and returns nothing. The figure of one sample
// per clock is set by the feedback loop: the stored outputs pass combinationally
// through the row of tap multipliers, the adder chain along the cells and the
// rounding and saturation logic back into the first cell's registers. Results
// wait in an output register backed by one skid entry, so input is taken until
// both are full. Coefficients are signed Q4.14, samples signed Q1.15; the sum is
// rounded half up and saturated to 16 bits, with the saturation flag in m_tuser.
// ----------------------------------------------------------------------------
module direct_form_one_iir_fir_filter
    import dfiir_pkg::*;
#(
    parameter int ORDER = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream. s_tdata: [15:0] sample. s_tuser: [0] operation.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    // Output stream. m_tdata: [15:0] filtered. m_tuser: [0] saturated.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [0:0]           m_tuser,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    logic signed [COEF_W-1:0]   coef_b_reg [NUM_COEF];
    logic signed [COEF_W-1:0]   coef_a_reg [NUM_COEF];
    logic                       feedback_en_reg;

    logic                       accept;
    logic signed [SAMPLE_W-1:0] x;
    cell_ctrl_t                 ctrl;

    logic signed [SAMPLE_W-1:0] u_chain   [ORDER+1];
    logic signed [SAMPLE_W-1:0] y_chain   [ORDER+1];
    logic signed [ACC_W-1:0]    acc_chain [ORDER+1];
    logic signed [PROD_W-1:0]   prod_b0;

    logic signed [ACC_W-1:0]    acc_round;
    logic signed [RND_W-1:0]    rnd;
    result_t                    result;
    result_t                    out_data;
    buf_status_t                buf_status;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_b_reg[i] <= '0;
                coef_a_reg[i] <= '0;
            end
            feedback_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF_B0:     coef_b_reg[0]   <= cfg_data;
                REG_COEF_B1:     coef_b_reg[1]   <= cfg_data;
                REG_COEF_B2:     coef_b_reg[2]   <= cfg_data;
                REG_COEF_B3:     coef_b_reg[3]   <= cfg_data;
                REG_COEF_A1:     coef_a_reg[1]   <= cfg_data;
                REG_COEF_A2:     coef_a_reg[2]   <= cfg_data;
                REG_COEF_A3:     coef_a_reg[3]   <= cfg_data;
                REG_FEEDBACK_EN: feedback_en_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side and cell control
    // ------------------------------------------------------------------
    assign s_tready = !buf_status.skid_valid;
    assign accept   = s_tvalid && s_tready;
    assign x        = $signed(s_tdata);

    assign ctrl.shift    = accept && (op_t'(s_tuser[0]) == OP_FILTER);
    assign ctrl.preset   = accept && (op_t'(s_tuser[0]) == OP_PRESET);
    assign ctrl.feedback = feedback_en_reg;

    // The current sample enters the chain directly; its product starts the sum.
    assign prod_b0      = coef_b_reg[0] * x;
    assign u_chain[0]   = x;
    assign acc_chain[0] = ACC_W'(prod_b0);
    assign y_chain[0]   = result.filtered;

    for (genvar k = 1; k <= ORDER; k++)
    begin : g_cell
        dfiir_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .preset_value (x),
            .u_in         (u_chain[k-1]),
            .y_in         (y_chain[k-1]),
            .coef_b       (coef_b_reg[k]),
            .coef_a       (coef_a_reg[k]),
            .acc_in       (acc_chain[k-1]),
            .u_out        (u_chain[k]),
            .y_out        (y_chain[k]),
            .acc_out      (acc_chain[k])
        );
    end

    // ------------------------------------------------------------------
    // Rounding and saturation
    // ------------------------------------------------------------------
    assign acc_round = acc_chain[ORDER] + ROUND_HALF;
    assign rnd       = acc_round[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        result.saturated = 1'b0;
        result.filtered  = rnd[SAMPLE_W-1:0];
        priority if (rnd > RND_MAX)
        begin
            result.saturated = 1'b1;
            result.filtered  = RND_MAX[SAMPLE_W-1:0];
        end
        else if (rnd < RND_MIN)
        begin
            result.saturated = 1'b1;
            result.filtered  = RND_MIN[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    dfiir_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ctrl.shift),
        .push_data (result),
        .pop_ready (m_tready),
        .out_data  (out_data),
        .status    (buf_status)
    );

    assign m_tvalid   = buf_status.out_valid;
    assign m_tdata    = out_data.filtered;
    assign m_tuser[0] = out_data.saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "direct_form_one_iir_fir_filter_assert.svh"

    `DFIIR_ASSERT_SAME(a_skid_behind_out, buf_status.skid_valid, buf_status.out_valid)
    `DFIIR_ASSERT_SAME(a_sat_at_limit, m_tvalid && m_tuser[0], (m_tdata == 16'h7fff) || (m_tdata == 16'h8000))
    `DFIIR_ASSERT_NEXT(a_preset_loads, ctrl.preset, (u_chain[1] == $past(x)) && (y_chain[1] == $past(x)))

endmodule

@@ test/tb_direct_form_one_iir_fir_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_form_one_iir_fir_filter
// Self-checking testbench of the direct form I IIR/FIR filter.
// ----------------------------------------------------------------------------
// A short table of directed transactions covers reset state, coefficient and
// sample extremes, rounding at the half, presets and the feedback switch. It is
// followed by random coefficient settings, each with a burst of random samples
// and occasional presets. Samples without a table result are predicted by a
// local fixed-point model; both stream sides stall at random, and the output
// side is held off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_direct_form_one_iir_fir_filter;
    import dfiir_pkg::*;

    localparam int TAPS            = 3;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int MAX_REPORTS     = 40;

    typedef enum {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        cfg_reg_t                   regidx;
        logic [COEF_W-1:0]          value;
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
        bit                         typed;
        result_t                    want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    // Filter state and settings as the block should hold them.
    logic signed [COEF_W-1:0]   coef_b [0:TAPS];
    logic signed [COEF_W-1:0]   coef_a [0:TAPS];
    bit                         feedback_on;
    logic signed [SAMPLE_W-1:0] input_hist [0:TAPS];
    logic signed [SAMPLE_W-1:0] output_hist [0:TAPS];

    result_t   pending_outputs[$];
    stim_row_t directed_rows[$];

    int  errors;
    int  n_items;
    int  n_presets;
    int  n_results;
    int  n_saturated;
    int  n_settings;
    int  cycle_count;
    bit  quiet;
    bit  hold_req;

    direct_form_one_iir_fir_filter #(
        .ORDER(TAPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Applies one input transaction to the local filter state and returns 1
    // with the expected output when the transaction produces one.
    function automatic bit advance_filter(input op_t op,
                                          input logic signed [SAMPLE_W-1:0] x,
                                          output result_t res);
        longint acc;
        longint r;
        res = '0;
        if (op == OP_PRESET) begin
            for (int i = 0; i <= TAPS; i++) begin
                input_hist[i]  = x;
                output_hist[i] = x;
            end
            return 1'b0;
        end
        for (int i = TAPS; i > 0; i--) begin
            input_hist[i]  = input_hist[i-1];
            output_hist[i] = output_hist[i-1];
        end
        input_hist[0] = x;
        acc = longint'(coef_b[0]) * longint'(input_hist[0]);
        for (int i = 1; i <= TAPS; i++) begin
            acc += longint'(coef_b[i]) * longint'(input_hist[i]);
            if (feedback_on)
                acc -= longint'(coef_a[i]) * longint'(output_hist[i]);
        end
        // Arithmetic shift of a signed value floors, so this rounds half up.
        r = (acc + 64'sd8192) >>> FRAC_SHIFT;
        if (r > 32767) begin
            r = 32767;
            res.saturated = 1'b1;
        end else if (r < -32768) begin
            r = -32768;
            res.saturated = 1'b1;
        end
        output_hist[0] = r[SAMPLE_W-1:0];
        res.filtered   = r[SAMPLE_W-1:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     n_results, what, got, want);
        errors++;
    endtask

    // The block is idle once every expected output has come out and any
    // trailing preset has had time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t regidx, input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= regidx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (regidx)
            REG_COEF_B0:     coef_b[0] = value;
            REG_COEF_B1:     coef_b[1] = value;
            REG_COEF_B2:     coef_b[2] = value;
            REG_COEF_B3:     coef_b[3] = value;
            REG_COEF_A1:     coef_a[1] = value;
            REG_COEF_A2:     coef_a[2] = value;
            REG_COEF_A3:     coef_a[3] = value;
            REG_FEEDBACK_EN: feedback_on = value[0];
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input op_t op, input logic signed [SAMPLE_W-1:0] x,
                               input bit typed, input result_t want);
        result_t predicted;
        if (!quiet && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (!quiet && $urandom_range(0, 99) < 32)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= x;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_items++;
        if (op == OP_PRESET)
            n_presets++;
        if (advance_filter(op, x, predicted))
            pending_outputs.push_back(typed ? want : predicted);
    endtask

    task automatic add_write(input cfg_reg_t regidx, input int value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, regidx: regidx, value: value[COEF_W-1:0],
                op: OP_FILTER, sample: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_item(input op_t op, input int sample);
        stim_row_t row;
        row = '{kind: ROW_ITEM, regidx: REG_COEF_B0, value: '0, op: op,
                sample: sample[SAMPLE_W-1:0], typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(input int sample, input int filtered, input bit sat);
        stim_row_t row;
        row = '{kind: ROW_ITEM, regidx: REG_COEF_B0, value: '0, op: OP_FILTER,
                sample: sample[SAMPLE_W-1:0], typed: 1'b1, want: '0};
        row.want.filtered  = filtered[SAMPLE_W-1:0];
        row.want.saturated = sat;
        directed_rows.push_back(row);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 18'sd131071;
            1:       return -18'sd131072;
            2, 3, 4: return COEF_W'($urandom_range(0, 8192) - 4096);
            5, 6:    return COEF_W'($urandom_range(0, 32768) - 16384);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return SAMPLE_W'($urandom_range(0, 1024) - 512);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Output side: random stalls, a quiet window, and one long hold-off.
    initial begin : sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 32);
            end
        end
    end

    always @(posedge clk) begin : out_check
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("output with nothing pending, filtered",
                                $signed(m_tdata), 0);
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.filtered)
                    report_mismatch("filtered", $signed(m_tdata), want.filtered);
                if (m_tuser[0] !== want.saturated)
                    report_mismatch("saturated", m_tuser[0], want.saturated);
                if (m_tuser[0] === 1'b1)
                    n_saturated++;
            end
            n_results++;
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d outputs still pending",
                 cycle_count, pending_outputs.size());
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        result_t none;
        int      rand_index;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        none      = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        errors = 0; n_items = 0; n_presets = 0; n_results = 0;
        n_saturated = 0; n_settings = 1;
        rand_index = 0;
        for (int i = 0; i <= TAPS; i++) begin
            coef_b[i]      = '0;
            coef_a[i]      = '0;
            input_hist[i]  = '0;
            output_hist[i] = '0;
        end
        feedback_on = 1'b0;

        // With all coefficients cleared at reset every output is zero.
        add_checked(32767, 0, 1'b0);
        add_item(OP_PRESET, -32768);
        add_checked(-32768, 0, 1'b0);
        // Largest and smallest b0 drive the sum far outside the output range.
        add_write(REG_COEF_B0, 131071);
        add_checked(32767, 32767, 1'b1);
        add_checked(-32768, -32768, 1'b1);
        add_checked(0, 0, 1'b0);
        add_write(REG_COEF_B0, -131072);
        add_checked(-32768, 32767, 1'b1);
        add_checked(32767, -32768, 1'b1);
        add_item(OP_FILTER, 1);
        // A gain of one half puts odd samples exactly on the rounding half.
        add_write(REG_COEF_B0, 8192);
        add_checked(1, 1, 1'b0);
        add_checked(-1, 0, 1'b0);
        add_write(REG_COEF_B1, 16384);
        add_write(REG_COEF_B2, -16384);
        add_write(REG_COEF_B3, 131071);
        add_item(OP_FILTER, 1000);
        add_item(OP_FILTER, -2000);
        add_item(OP_FILTER, 32767);
        add_item(OP_FILTER, 5);
        add_item(OP_PRESET, 12345);
        add_item(OP_FILTER, 100);
        add_write(REG_COEF_B3, -131072);
        add_write(REG_COEF_A1, -8192);
        add_write(REG_COEF_A2, 4096);
        add_write(REG_COEF_A3, -131072);
        add_write(REG_FEEDBACK_EN, 1);
        add_item(OP_PRESET, -32768);
        add_item(OP_FILTER, 300);
        add_item(OP_FILTER, -300);
        add_item(OP_FILTER, 32767);
        add_write(REG_COEF_A1, 131071);
        add_write(REG_COEF_A2, -131072);
        add_write(REG_COEF_A3, 131071);
        add_item(OP_FILTER, -32768);
        add_item(OP_FILTER, 7);
        // Only bit 0 of the enable counts; the output history keeps shifting
        // while feedback is off and is used again once it is back on.
        add_write(REG_FEEDBACK_EN, 'h3fffe);
        add_item(OP_FILTER, 2000);
        add_write(REG_FEEDBACK_EN, 'h20001);
        add_item(OP_FILTER, -4);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(directed_rows[i].regidx, directed_rows[i].value);
            end else begin
                send_sample(directed_rows[i].op, directed_rows[i].sample,
                            directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            for (int r = REG_COEF_B0; r <= REG_COEF_A3; r++)
                write_reg(cfg_reg_t'(r), pick_coef());
            // Feedback follows bit 0 of a random data word, so it is on in about half the settings.
            write_reg(REG_FEEDBACK_EN, COEF_W'($urandom));
            n_settings++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (rand_index == 100)
                    hold_req = 1'b1;
                quiet = (rand_index >= 250 && rand_index < 370);
                send_sample(($urandom_range(0, 99) < 10) ? OP_PRESET : OP_FILTER,
                            pick_sample(), 1'b0, none);
                rand_index++;
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d input transactions (%0d presets) over %0d settings",
                 n_items, n_presets, n_settings);
        $display("checked %0d filtered outputs, %0d of them saturated, in %0d cycles",
                 n_results, n_saturated, cycle_count);
        if (errors == 0 && pending_outputs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dfiir_pkg.sv
hdl/dfiir_cell.sv
hdl/dfiir_outbuf.sv
hdl/direct_form_one_iir_fir_filter.sv
test/tb_direct_form_one_iir_fir_filter.sv
